>>> rtl/pft_pkg.sv
// Shared types, constants and helpers for the permutation footrule top-k search.
package pft_pkg;

    // Sizes of the search
    localparam int MAX_REFS = 256;
    localparam int TOP_K    = 10;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int REF_W   = 8;
    localparam int RANK_W  = 8;
    localparam int POS_W   = 8;
    localparam int ID_W    = 32;
    localparam int SCORE_W = 16;
    localparam int REFS_W  = 9;

    // Derived widths
    localparam int RANK_AW = $clog2(MAX_REFS);
    localparam int IDX_W   = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    localparam logic [SCORE_W-1:0] EMPTY_SCORE = '1;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STREAM = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    // One queued input item
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [REF_W-1:0]  ref_id;
        logic [RANK_W-1:0] rank;
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic [ID_W-1:0]    object_id;
        logic [SCORE_W-1:0] score;
        logic               last;
    } res_t;

    // One entry of the best list
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } entry_t;

    // True when entry a ranks worse than entry b: larger score, then larger id
    function automatic logic is_worse(entry_t a, entry_t b);
        logic worse;
        if (a.score != b.score)
        begin
            worse = (a.score > b.score);
        end
        else
        begin
            worse = (a.id > b.id);
        end
        return worse;
    endfunction

endpackage

>>> rtl/permutation_footrule_topk.sv
// Permutation-index k-nearest search scored by the Spearman footrule distance.
//
// Items enter a two-entry command queue and are executed one at a time by the
// back end. A rank load or a start completes in the back-end cycle that takes
// it; a streamed reference id passes through the registered read of the rank
// table RAM into the accumulate state, and on an object's last position also
// through the offer state, where the score is inserted into the sorted best
// list when below its worst score. A readout pushes the ten list entries, best
// first, into the two-entry result queue and stalls while that queue is full
// because the consumer holds pop low. The rank table needs no clearing pass
// after reset. refs_in_use may be written only while the block is idle.
module permutation_footrule_topk (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [pft_pkg::FUNC_W-1:0]  func,
    input  logic [pft_pkg::REF_W-1:0]   ref_id,
    input  logic [pft_pkg::RANK_W-1:0]  rank,
    output logic                        empty,
    input  logic                        pop,
    output logic [pft_pkg::ID_W-1:0]    object_id,
    output logic [pft_pkg::SCORE_W-1:0] score,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pft_pkg::REFS_W-1:0]  refs_in_use
);

    logic [pft_pkg::REFS_W-1:0] refs_reg, refs_next;
    logic [pft_pkg::REFS_W-1:0] refs_active;
    logic                       cmd_valid, cmd_pop;
    pft_pkg::cmd_t              cmd;
    logic                       res_full, res_push;
    pft_pkg::res_t              res_in, res_out;

    // Hold the configuration register; always ready for a write
    assign cfg_ready = 1'b1;
    assign refs_next = cfg_valid ? refs_in_use : refs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refs_reg <= pft_pkg::REFS_W'(pft_pkg::MAX_REFS);
        end
        else
        begin
            refs_reg <= refs_next;
        end
    end

    // Clamp the object length to one through the table size
    always_comb
    begin
        if (refs_reg == '0)
        begin
            refs_active = pft_pkg::REFS_W'(1);
        end
        else if (refs_reg > pft_pkg::REFS_W'(pft_pkg::MAX_REFS))
        begin
            refs_active = pft_pkg::REFS_W'(pft_pkg::MAX_REFS);
        end
        else
        begin
            refs_active = refs_reg;
        end
    end

    pft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .ref_id    (ref_id),
        .rank      (rank),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    pft_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .refs_active (refs_active),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .res_full    (res_full),
        .res_push    (res_push),
        .res         (res_in)
    );

    pft_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    // Split the result transaction onto its ports
    assign object_id = res_out.object_id;
    assign score     = res_out.score;
    assign last      = res_out.last;

endmodule

>>> rtl/pft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/pft_front.sv
// Front end: accepts input transactions into a two-entry command queue.
module pft_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [pft_pkg::FUNC_W-1:0] func,
    input  logic [pft_pkg::REF_W-1:0]  ref_id,
    input  logic [pft_pkg::RANK_W-1:0] rank,
    output logic                      cmd_valid,
    output pft_pkg::cmd_t             cmd,
    input  logic                      cmd_pop
);

    pft_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= '{func: func, ref_id: ref_id, rank: rank};
        end
    end

endmodule

>>> rtl/pft_outq.sv
// Result queue: two-entry buffer between the back end and the result ports.
module pft_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_push,
    input  pft_pkg::res_t res_in,
    output logic          res_full,
    output logic          empty,
    input  logic          pop,
    output pft_pkg::res_t res_out
);

    pft_pkg::res_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    logic          do_push, do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_out  = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

>>> rtl/pft_back.sv
// Back end: rank table, footrule accumulation, sorted best list and readout.
module pft_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pft_pkg::REFS_W-1:0] refs_active,
    input  logic                       cmd_valid,
    input  pft_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    input  logic                       res_full,
    output logic                       res_push,
    output pft_pkg::res_t              res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ACC   = 2'd1;
    localparam logic [1:0] ST_OFFER = 2'd2;
    localparam logic [1:0] ST_READ  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [pft_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [pft_pkg::ID_W-1:0]      obj_reg, obj_next;
    logic [pft_pkg::SCORE_W-1:0]   sum_reg, sum_next;
    logic [pft_pkg::IDX_W-1:0]     cnt_reg, cnt_next;
    logic                          oob_reg, oob_next;
    pft_pkg::entry_t               list_reg [pft_pkg::TOP_K];
    pft_pkg::entry_t               list_next [pft_pkg::TOP_K];

    logic                          in_table;
    logic                          ram_we, ram_re;
    logic [pft_pkg::RANK_W-1:0]    ram_rdata;
    logic [pft_pkg::RANK_W-1:0]    q_rank;
    logic [pft_pkg::POS_W-1:0]     diff;
    logic [pft_pkg::SCORE_W:0]     sum_wide;
    logic [pft_pkg::SCORE_W-1:0]   sum_sat;
    logic [pft_pkg::REFS_W-1:0]    pos_plus;
    logic                          last_pos;
    pft_pkg::entry_t               cand;
    logic [pft_pkg::TOP_K-1:0]     worse_vec;
    logic                          accept_cand;
    pft_pkg::entry_t               ins_list [pft_pkg::TOP_K];

    // Rank table lookup in the query's ordering
    assign in_table = ({1'b0, cmd.ref_id} < pft_pkg::REFS_W'(pft_pkg::MAX_REFS));

    pft_ram #(
        .WIDTH(pft_pkg::RANK_W),
        .DEPTH(pft_pkg::MAX_REFS)
    ) u_rank_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.ref_id[pft_pkg::RANK_AW-1:0]),
        .wdata (cmd.rank),
        .re    (ram_re),
        .raddr (cmd.ref_id[pft_pkg::RANK_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Footrule term and saturating running sum
    always_comb
    begin
        q_rank   = oob_reg ? '0 : ram_rdata;
        diff     = (q_rank > pos_reg) ? (q_rank - pos_reg) : (pos_reg - q_rank);
        sum_wide = {1'b0, sum_reg} + {{(pft_pkg::SCORE_W + 1 - pft_pkg::POS_W){1'b0}}, diff};
        sum_sat  = sum_wide[pft_pkg::SCORE_W] ? pft_pkg::EMPTY_SCORE
                                               : sum_wide[pft_pkg::SCORE_W-1:0];
        pos_plus = {1'b0, pos_reg} + pft_pkg::REFS_W'(1);
        last_pos = (pos_plus >= refs_active);
    end

    // Sorted insertion of the finished object into the best list
    always_comb
    begin
        cand = '{id: obj_reg, score: sum_reg};
        for (int i = 0; i < pft_pkg::TOP_K; i++)
        begin
            worse_vec[i] = pft_pkg::is_worse(list_reg[i], cand);
        end
        accept_cand = (sum_reg < list_reg[pft_pkg::TOP_K-1].score);
        for (int i = 0; i < pft_pkg::TOP_K; i++)
        begin
            if (!worse_vec[i])
            begin
                ins_list[i] = list_reg[i];
            end
            else if (i == 0)
            begin
                ins_list[i] = cand;
            end
            else if (!worse_vec[(i > 0) ? i - 1 : 0])
            begin
                ins_list[i] = cand;
            end
            else
            begin
                ins_list[i] = list_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    // Sequence one command at a time
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        obj_next   = obj_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        oob_next   = oob_reg;
        list_next  = list_reg;
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        res_push   = 1'b0;
        res        = '{object_id: list_reg[cnt_reg].id,
                       score:     list_reg[cnt_reg].score,
                       last:      (cnt_reg == pft_pkg::IDX_W'(pft_pkg::TOP_K - 1))};

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.func)
                        pft_pkg::FUNC_LOAD:
                        begin
                            ram_we = in_table;
                        end
                        pft_pkg::FUNC_START:
                        begin
                            pos_next = '0;
                            obj_next = '0;
                            sum_next = '0;
                            for (int i = 0; i < pft_pkg::TOP_K; i++)
                            begin
                                list_next[i] = '{id: '0, score: pft_pkg::EMPTY_SCORE};
                            end
                        end
                        pft_pkg::FUNC_STREAM:
                        begin
                            ram_re     = 1'b1;
                            oob_next   = !in_table;
                            state_next = ST_ACC;
                        end
                        pft_pkg::FUNC_READ:
                        begin
                            cnt_next   = '0;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                sum_next = sum_sat;
                if (last_pos)
                begin
                    pos_next   = '0;
                    state_next = ST_OFFER;
                end
                else
                begin
                    pos_next   = pos_plus[pft_pkg::POS_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_OFFER:
            begin
                if (accept_cand)
                begin
                    list_next = ins_list;
                end
                sum_next   = '0;
                obj_next   = obj_reg + pft_pkg::ID_W'(1);
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (cnt_reg == pft_pkg::IDX_W'(pft_pkg::TOP_K - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + pft_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            obj_reg   <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            oob_reg   <= 1'b0;
            for (int i = 0; i < pft_pkg::TOP_K; i++)
            begin
                list_reg[i] <= '{id: '0, score: pft_pkg::EMPTY_SCORE};
            end
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            obj_reg   <= obj_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            oob_reg   <= oob_next;
            list_reg  <= list_next;
        end
    end

endmodule
